// ----- design/pmpw_pkg.sv -----
// Shared types and constants for the page mode pixel writer.
package pmpw_pkg;

  localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
  localparam logic [7:0] COL_LOW_MASK  = 8'h0F;
  localparam logic [7:0] COL_HIGH_CMD  = 8'h10;
  localparam logic [5:0] OFFSET_RESET  = 6'd18;

  // Position of the byte being shown within one pixel write
  typedef enum logic [1:0] {
    SEQ_PAGE,
    SEQ_COL_LO,
    SEQ_COL_HI,
    SEQ_DATA
  } seq_e;

  // One pixel write ready for the byte sequencer
  typedef struct packed {
    logic [3:0] page;
    logic [7:0] col;
    logic [7:0] data;
  } pix_cmd_t;

endpackage

// ----- design/pmpw_shadow_ram.sv -----
// Shadow frame memory with a clearing pass after reset and write-to-read forwarding.
module pmpw_shadow_ram #(
  parameter int Depth = 768,
  parameter int AddrW = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [7:0]       rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [7:0]       wr_data_i,
  output logic             clear_done_o
);

  logic [7:0]       mem [Depth];
  logic [7:0]       rd_q;
  logic [AddrW-1:0] clr_addr_q, clr_addr_d;
  logic             clr_busy_q, clr_busy_d;

  always_comb begin
    clr_addr_d = clr_addr_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      if (clr_addr_q == AddrW'(Depth - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= 8'h00;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Forward a write that lands in the same cycle as the read of its address
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_q <= wr_data_i;
      end else begin
        rd_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o    = rd_q;
  assign clear_done_o = !clr_busy_q;

endmodule

// ----- design/pmpw_byte_seq.sv -----
// Output sequencer: turns one pixel write into three command bytes and one data byte.
module pmpw_byte_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_valid_i,
  input  pmpw_pkg::pix_cmd_t load_cmd_i,
  output logic              load_ready_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // out_byte[7:0]
  output logic              m_axis_tuser,   // is_data
  output logic              m_axis_tlast
);
  import pmpw_pkg::*;

  seq_e     seq_q, seq_d;
  logic     valid_q, valid_d;
  pix_cmd_t cmd_q;
  logic     load;

  assign load_ready_o = !valid_q || ((seq_q == SEQ_DATA) && m_axis_tready);
  assign load         = load_valid_i && load_ready_o;

  // Next state
  always_comb begin
    seq_d   = seq_q;
    valid_d = valid_q;
    if (load) begin
      seq_d   = SEQ_PAGE;
      valid_d = 1'b1;
    end else if (valid_q && m_axis_tready) begin
      unique case (seq_q)
        SEQ_PAGE:   seq_d = SEQ_COL_LO;
        SEQ_COL_LO: seq_d = SEQ_COL_HI;
        SEQ_COL_HI: seq_d = SEQ_DATA;
        SEQ_DATA:   valid_d = 1'b0;
        default:    seq_d = SEQ_PAGE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= SEQ_PAGE;
      valid_q <= 1'b0;
    end else begin
      seq_q   <= seq_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= load_cmd_i;
    end
  end

  // Outputs
  always_comb begin
    m_axis_tvalid = valid_q;
    m_axis_tuser  = 1'b0;
    unique case (seq_q)
      SEQ_PAGE:   m_axis_tdata = PAGE_CMD_BASE + {4'h0, cmd_q.page};
      SEQ_COL_LO: m_axis_tdata = cmd_q.col & COL_LOW_MASK;
      SEQ_COL_HI: m_axis_tdata = COL_HIGH_CMD | {4'h0, cmd_q.col[7:4]};
      SEQ_DATA: begin
        m_axis_tdata = cmd_q.data;
        m_axis_tuser = 1'b1;
      end
      default:    m_axis_tdata = 8'h00;
    endcase
    m_axis_tlast = m_axis_tuser && valid_q;
  end

endmodule

// ----- design/page_mode_pixel_writer.sv -----
// Top level of the page mode pixel writer.
//
// Pixel writes arrive on the s_axis channel, one per transfer. A pixel inside
// the display updates one bit of a shadow frame byte (one column of 8 rows)
// and sends four bytes on m_axis: page command, low column command, high
// column command, then the updated data byte (tuser high, tlast high).
// Pixels outside the display are accepted and dropped without output.
// The column commands use x plus the column offset from the cfg channel,
// which is always ready. The offset is to be written only while the block
// is idle; the block itself does not enforce this. An input transfer is
// registered in the read stage, then loaded into the byte sequencer.
// The four-byte output sequence sets the pixel rate; a pixel can wait in
// the read stage while the previous one drains. Dropped pixels do not
// enter the read stage. After reset the shadow memory is cleared one byte
// a cycle, all DISPLAY_WIDTH * ceil(DISPLAY_HEIGHT/8) bytes (768 by
// default); s_axis tready stays low until that pass is done.
// When the receiver stalls, the current byte holds on m_axis and the input
// side stops once the read stage is full.
module page_mode_pixel_writer #(
  parameter int DISPLAY_WIDTH  = 96,
  parameter int DISPLAY_HEIGHT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // pixel_x[6:0], pixel_y[13:7], pixel_on[14], zero[15]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
  output logic        m_axis_tuser,   // is_data
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [5:0]  cfg_data_i
);
  import pmpw_pkg::*;

  localparam int PageCount = (DISPLAY_HEIGHT + 7) / 8;
  localparam int Depth     = DISPLAY_WIDTH * PageCount;
  localparam int AddrW     = (Depth > 1) ? $clog2(Depth) : 1;

  logic [6:0]       in_x, in_y;
  logic             in_on, in_fits, accept, take;
  logic [AddrW-1:0] rd_addr;
  logic [7:0]       rd_data, new_byte, bit_mask;
  logic             clear_done;

  logic [5:0]       offset_q;
  logic             a_valid_q, a_valid_d;
  logic [3:0]       a_page_q;
  logic [7:0]       a_col_q;
  logic [2:0]       a_bit_q;
  logic             a_on_q;
  logic [AddrW-1:0] a_addr_q;
  logic             a_move, load_ready;
  pix_cmd_t         a_cmd;

  assign in_x  = s_axis_tdata[6:0];
  assign in_y  = s_axis_tdata[13:7];
  assign in_on = s_axis_tdata[14];

  assign in_fits = (32'(in_x) < DISPLAY_WIDTH) && (32'(in_y) < DISPLAY_HEIGHT);
  assign rd_addr = AddrW'(32'(in_y[6:3]) * DISPLAY_WIDTH + 32'(in_x));

  assign a_move        = a_valid_q && load_ready;
  assign s_axis_tready = clear_done && (!a_valid_q || load_ready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign take          = accept && in_fits;
  assign a_valid_d     = take ? 1'b1 : (a_move ? 1'b0 : a_valid_q);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q  <= OFFSET_RESET;
      a_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        offset_q <= cfg_data_i;
      end
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      a_page_q <= in_y[6:3];
      a_col_q  <= {1'b0, in_x} + {2'b00, offset_q};
      a_bit_q  <= in_y[2:0];
      a_on_q   <= in_on;
      a_addr_q <= rd_addr;
    end
  end

  // Set or clear the pixel bit in the byte read back from the shadow frame
  assign bit_mask = 8'h01 << a_bit_q;
  assign new_byte = a_on_q ? (rd_data | bit_mask) : (rd_data & ~bit_mask);

  assign a_cmd.page = a_page_q;
  assign a_cmd.col  = a_col_q;
  assign a_cmd.data = new_byte;

  pmpw_shadow_ram #(
    .Depth(Depth),
    .AddrW(AddrW)
  ) u_ram (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (take),
    .rd_addr_i   (rd_addr),
    .rd_data_o   (rd_data),
    .wr_en_i     (a_move),
    .wr_addr_i   (a_addr_q),
    .wr_data_i   (new_byte),
    .clear_done_o(clear_done)
  );

  pmpw_byte_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (a_valid_q),
    .load_cmd_i   (a_cmd),
    .load_ready_o (load_ready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

// ----- design/pmpw_checker.sv -----
// Port-level checks for the page mode pixel writer, bound to the top level.
module pmpw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // Hold input side closed while in reset and the clearing pass starts
  a_reset_closed: assert property (@(posedge clk_i) !rst_ni |=> !s_axis_tready)
    else $error("input ready during reset");

  // Only the data byte closes a pixel write
  a_last_is_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser))
    else $error("tlast and tuser disagree");

  // A new pixel write starts with a command byte after a last transfer
  a_last_then_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !(m_axis_tvalid && m_axis_tlast))
    else $error("two data bytes in a row");

  // Hold the byte while the receiver stalls
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("output changed under stall");

endmodule

bind page_mode_pixel_writer pmpw_checker u_pmpw_checker (.*);
